// ===== sv/rebd_pkg.sv =====
// ----------------------------------------------------------------------------
// rebd_pkg
// Shared types, codes and the full-step decode table for the rotary
// encoder / push button decoder.
// ----------------------------------------------------------------------------
package rebd_pkg;

	localparam int COUNT_BITS_DEF = 16;

	// request mode codes
	localparam logic [1:0] MODE_ENC  = 2'd0;
	localparam logic [1:0] MODE_PUSH = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	// step direction codes
	localparam logic [1:0] DIR_STILL = 2'd0;
	localparam logic [1:0] DIR_CW    = 2'd1;
	localparam logic [1:0] DIR_CCW   = 2'd2;

	// event flag bit positions
	localparam int FLAG_SHORT = 0;
	localparam int FLAG_LONG  = 1;
	localparam int FLAG_ROT   = 2;

	// configuration register indexes
	localparam logic CFG_LONG  = 1'b0;
	localparam logic CFG_SHORT = 1'b1;

	localparam logic [15:0] LONG_PRESS_RST  = 16'd1000;
	localparam logic [15:0] SHORT_PRESS_RST = 16'd8;

	// table entry: emit code in [5:4], next state in [2:0]
	localparam logic [1:0] EMIT_NONE = 2'b00;
	localparam logic [1:0] EMIT_CW   = 2'b01;
	localparam logic [1:0] EMIT_CCW  = 2'b10;

	localparam logic [5:0] E_CW  = 6'h10;
	localparam logic [5:0] E_CCW = 6'h20;

	// rows: current state, columns: pins {a, b}
	localparam logic [5:0] STEP_TABLE [0:7][0:3] = '{
		'{6'h0, 6'h2, 6'h4, 6'h0},
		'{6'h3, 6'h0, 6'h1, E_CW},
		'{6'h3, 6'h2, 6'h0, 6'h0},
		'{6'h3, 6'h2, 6'h1, 6'h0},
		'{6'h6, 6'h0, 6'h4, 6'h0},
		'{6'h6, 6'h5, 6'h0, E_CCW},
		'{6'h6, 6'h5, 6'h4, 6'h0},
		'{6'h0, 6'h2, 6'h4, 6'h0}
	};

	typedef struct packed {
		logic [1:0]  mode;
		logic        pin_a;
		logic        pin_b;
		logic        push_level;
		logic [31:0] time_ms;
	} in_req_t;

	typedef struct packed {
		logic [1:0]         step_dir;
		logic signed [15:0] count_value;
		logic [2:0]         event_flags;
	} out_res_t;

	typedef struct packed {
		logic [1:0] dir;
		logic [2:0] next_state;
		logic       rot;
	} enc_upd_t;

	typedef struct packed {
		logic short_hit;
		logic long_hit;
	} press_upd_t;

endpackage

// ===== sv/rebd_enc.sv =====
// ----------------------------------------------------------------------------
// rebd_enc
// Full-step quadrature table decode and saturating step count update.
// ----------------------------------------------------------------------------
module rebd_enc #(
	parameter int COUNT_BITS = rebd_pkg::COUNT_BITS_DEF
) (
	input  logic [2:0]            state,
	input  logic                  pin_a,
	input  logic                  pin_b,
	input  logic [COUNT_BITS-1:0] count,
	output rebd_pkg::enc_upd_t    upd,
	output logic [COUNT_BITS-1:0] count_next
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
	localparam logic [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
	localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

	logic [5:0] entry;
	logic [1:0] emit;

	always_comb begin
		entry = rebd_pkg::STEP_TABLE[state][{pin_a, pin_b}];
		emit = entry[5:4];
		upd.next_state = entry[2:0];
		upd.dir = rebd_pkg::DIR_STILL;
		upd.rot = 1'b0;
		count_next = count;
		case (emit)
			rebd_pkg::EMIT_CCW: begin
				upd.dir = rebd_pkg::DIR_CCW;
				upd.rot = 1'b1;
				if (count != CNT_MAX) begin
					count_next = count + CNT_ONE;
				end
			end
			rebd_pkg::EMIT_CW: begin
				upd.dir = rebd_pkg::DIR_CW;
				upd.rot = 1'b1;
				if (count != CNT_MIN) begin
					count_next = count - CNT_ONE;
				end
			end
			default: begin
				upd.dir = rebd_pkg::DIR_STILL;
			end
		endcase
	end

endmodule

// ===== sv/rebd_push.sv =====
// ----------------------------------------------------------------------------
// rebd_push
// Hold time measurement on button release against the press limits.
// ----------------------------------------------------------------------------
module rebd_push (
	input  logic [31:0]          time_ms,
	input  logic [31:0]          press_start,
	input  logic [15:0]          long_press_ms,
	input  logic [15:0]          short_press_ms,
	output rebd_pkg::press_upd_t upd
);

	logic [31:0] held;

	always_comb begin
		// modulo 2^32 so a wrapped time stamp still measures right
		held = time_ms - press_start;
		upd.long_hit = held > {16'd0, long_press_ms};
		upd.short_hit = !upd.long_hit && (held > {16'd0, short_press_ms});
	end

endmodule

// ===== sv/rotary_encoder_button_decoder_top.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_button_decoder_top
// Rotary encoder step decoder with push button press timing.
// ----------------------------------------------------------------------------
// Requests enter on in_valid / in_stall as in_data: an encoder pin change, a
// push pin edge with its millisecond time stamp, or a read that returns the
// count and event flags and then clears both. Every request gives exactly
// one result on out_valid / out_stall as out_data.
// A request taken is held in the input register; when it fires, the table
// step, count update and press compare run and load the result register,
// which raises out_valid. One request per cycle is sustained while the
// receiver does not stall: the input register and the result register both
// hold a request, so a new one is taken while a result waits.
// When the receiver stalls, the result holds; the input register still
// takes one more request, and in_stall rises only once both are full.
// Reset clears the encoder state, count, flags and press start and sets the
// press limits to 1000 ms and 8 ms. Limits are written on cfg_we with
// cfg_index 0 for the long limit and 1 for the short limit.
// ----------------------------------------------------------------------------
module rotary_encoder_button_decoder_top #(
	parameter int COUNT_BITS = rebd_pkg::COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rebd_pkg::in_req_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output rebd_pkg::out_res_t out_data,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data
);

	rebd_pkg::in_req_t    req_s1;
	logic                 valid_s1;
	logic                 out_valid_q;
	rebd_pkg::out_res_t   out_data_q;

	logic [2:0]            enc_state_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [31:0]           press_start_q;
	logic [2:0]            flags_q;
	logic [15:0]           long_press_q;
	logic [15:0]           short_press_q;

	rebd_pkg::enc_upd_t    enc_upd;
	rebd_pkg::press_upd_t  press_upd;
	logic [COUNT_BITS-1:0] enc_count;

	logic                  fire;
	logic                  accept;
	logic                  is_enc;
	logic                  is_push;
	logic                  is_read;
	logic                  is_release;
	logic [COUNT_BITS-1:0] count_new;
	logic [2:0]            flags_new;
	logic signed [31:0]    count_ext;
	rebd_pkg::out_res_t    res;

	rebd_enc #(
		.COUNT_BITS(COUNT_BITS)
	) u_enc (
		.state      (enc_state_q),
		.pin_a      (req_s1.pin_a),
		.pin_b      (req_s1.pin_b),
		.count      (count_q),
		.upd        (enc_upd),
		.count_next (enc_count)
	);

	rebd_push u_push (
		.time_ms        (req_s1.time_ms),
		.press_start    (press_start_q),
		.long_press_ms  (long_press_q),
		.short_press_ms (short_press_q),
		.upd            (press_upd)
	);

	assign fire = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;
	assign accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_comb begin
		is_enc = req_s1.mode == rebd_pkg::MODE_ENC;
		is_push = req_s1.mode == rebd_pkg::MODE_PUSH;
		is_read = req_s1.mode == rebd_pkg::MODE_READ;
		is_release = is_push && req_s1.push_level;

		count_new = is_enc ? enc_count : count_q;
		flags_new = flags_q;
		if (is_enc && enc_upd.rot) begin
			flags_new[rebd_pkg::FLAG_ROT] = 1'b1;
		end
		if (is_release && press_upd.long_hit) begin
			flags_new[rebd_pkg::FLAG_LONG] = 1'b1;
		end
		if (is_release && press_upd.short_hit) begin
			flags_new[rebd_pkg::FLAG_SHORT] = 1'b1;
		end

		// sign extend so a narrow count still reads as 16-bit two's complement
		count_ext = 32'(signed'(count_new));
		res.step_dir = is_enc ? enc_upd.dir : rebd_pkg::DIR_STILL;
		res.count_value = signed'(count_ext[15:0]);
		res.event_flags = flags_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			enc_state_q <= 3'd0;
			count_q <= '0;
			press_start_q <= 32'd0;
			flags_q <= 3'd0;
			long_press_q <= rebd_pkg::LONG_PRESS_RST;
			short_press_q <= rebd_pkg::SHORT_PRESS_RST;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end

			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (fire) begin
				if (is_enc) begin
					enc_state_q <= enc_upd.next_state;
				end
				if (is_push && !req_s1.push_level) begin
					press_start_q <= req_s1.time_ms;
				end
				count_q <= is_read ? '0 : count_new;
				flags_q <= is_read ? 3'd0 : flags_new;
			end

			if (cfg_we) begin
				case (cfg_index)
					rebd_pkg::CFG_LONG: begin
						long_press_q <= cfg_data;
					end
					rebd_pkg::CFG_SHORT: begin
						short_press_q <= cfg_data;
					end
					default: begin
						long_press_q <= long_press_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= in_data;
		end
		if (fire) begin
			out_data_q <= res;
		end
	end

endmodule
